// ===== rtl/core/hmlf_pkg.sv =====
// Shared types, constants and Morse tables for the hex Morse LED flasher.
package hmlf_pkg;

    localparam int VALUE_W        = 31;
    localparam int DIGIT_W        = 4;
    localparam int NIBBLES        = 8;
    localparam int SIG_W          = 4;
    localparam int POS_W          = 3;
    localparam int LEN_W          = 3;
    localparam int CODE_W         = 5;
    localparam int TICK_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_DIGITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYM_GAP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_GAP = 2'd3;

    localparam logic [TICK_W-1:0] SHORT_ON_RST  = 16'd100;
    localparam logic [TICK_W-1:0] LONG_ON_RST   = 16'd400;
    localparam logic [TICK_W-1:0] SYM_GAP_RST   = 16'd100;
    localparam logic [TICK_W-1:0] DIGIT_GAP_RST = 16'd500;
    localparam logic [TICK_W-1:0] TICK_SAT      = 16'hFFFF;

    typedef struct packed {
        logic               action;
        logic [VALUE_W-1:0] value;
    } hmlf_in_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic start_ignored;
    } hmlf_out_t;

    typedef struct packed {
        logic               action;
        logic [VALUE_W-1:0] value;
        logic [SIG_W-1:0]   sig_digits;
        logic               zero;
    } hmlf_item_t;

    function automatic logic [CODE_W-1:0] morse_code(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] c;
        case (d)
            4'h0:    c = 5'h1F;
            4'h1:    c = 5'h0F;
            4'h2:    c = 5'h07;
            4'h3:    c = 5'h03;
            4'h4:    c = 5'h01;
            4'h5:    c = 5'h00;
            4'h6:    c = 5'h10;
            4'h7:    c = 5'h18;
            4'h8:    c = 5'h1C;
            4'h9:    c = 5'h1E;
            4'hA:    c = 5'h01;
            4'hB:    c = 5'h08;
            4'hC:    c = 5'h0A;
            4'hD:    c = 5'h04;
            4'hE:    c = 5'h00;
            4'hF:    c = 5'h02;
            default: c = 5'h00;
        endcase
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] morse_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] n;
        case (d)
            4'hA:    n = 3'd2;
            4'hB:    n = 3'd4;
            4'hC:    n = 3'd4;
            4'hD:    n = 3'd3;
            4'hE:    n = 3'd1;
            4'hF:    n = 3'd4;
            default: n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic logic is_dash(input logic [DIGIT_W-1:0] d,
                                     input logic [POS_W-1:0] pos);
        logic [LEN_W-1:0]  n;
        logic [LEN_W-1:0]  sh;
        logic [CODE_W-1:0] c;
        n = morse_len(d);
        c = morse_code(d);
        sh = n - 3'd1 - pos;
        if (pos >= n)
        begin
            return 1'b0;
        end
        return c[sh];
    endfunction

    function automatic logic [DIGIT_W-1:0] nibble_of(input logic [VALUE_W-1:0] v,
                                                     input int i);
        logic [31:0] w;
        w = {1'b0, v} >> (4 * i);
        return w[DIGIT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/hmlf_front.sv =====
// Front end: accept requests, classify them and queue them for the sequencer.
module hmlf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hmlf_pkg::hmlf_in_t  in_data,
    output logic                q_valid,
    output hmlf_pkg::hmlf_item_t q_item,
    input  logic                q_pop
);

    localparam int DEPTH = 2;

    hmlf_pkg::hmlf_item_t mem_reg [DEPTH];
    hmlf_pkg::hmlf_item_t item;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    // count significant hex digits
    always_comb
    begin
        logic [hmlf_pkg::SIG_W-1:0] sig;
        sig = '0;
        for (int i = 0; i < hmlf_pkg::NIBBLES; i++)
        begin
            if (hmlf_pkg::nibble_of(in_data.value, i) != '0)
            begin
                sig = hmlf_pkg::SIG_W'(i + 1);
            end
        end
        item.action     = in_data.action;
        item.value      = in_data.value;
        item.sig_digits = sig;
        item.zero       = (in_data.value == '0);
    end

    assign in_ready = (count_reg != 2'(DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== rtl/core/hmlf_back.sv =====
// Back end: Morse sequencer, timing registers, digit store and result register.
module hmlf_back #(
    parameter int MAX_DIGITS = hmlf_pkg::MAX_DIGITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  hmlf_pkg::hmlf_item_t                q_item,
    output logic                                q_pop,
    input  logic                                cfg_valid,
    input  logic [hmlf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hmlf_pkg::TICK_W-1:0]         cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output hmlf_pkg::hmlf_out_t                 out_data
);

    localparam int REM_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_SGAP = 2'd2;
    localparam logic [1:0] PH_DGAP = 2'd3;

    logic [hmlf_pkg::DIGIT_W-1:0] store_reg [MAX_DIGITS];

    logic [hmlf_pkg::TICK_W-1:0] short_on_reg, long_on_reg, sym_gap_reg, digit_gap_reg;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [hmlf_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [hmlf_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic                        led_reg, led_next;
    logic                        zero_reg, zero_next;
    logic                        out_valid_reg;
    hmlf_pkg::hmlf_out_t         out_data_reg, out_data_next;

    logic                         take;
    logic                         load_store;
    logic [REM_W-1:0]             rem_dec;
    logic [IDX_W-1:0]             cur_idx;
    logic [hmlf_pkg::DIGIT_W-1:0] cur_digit;
    logic [hmlf_pkg::TICK_W-1:0]  tick_inc;
    logic [hmlf_pkg::POS_W-1:0]   pos_inc;
    logic [REM_W-1:0]             start_cnt;

    assign take    = q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = take;
    assign rem_dec = rem_reg - REM_W'(1);
    assign cur_idx = rem_dec[IDX_W-1:0];
    assign cur_digit = store_reg[cur_idx];
    assign tick_inc  = (tick_reg != hmlf_pkg::TICK_SAT) ? tick_reg + 16'd1 : tick_reg;
    assign pos_inc   = pos_reg + 3'd1;

    always_comb
    begin
        if (q_item.zero)
        begin
            start_cnt = REM_W'(1);
        end
        else if (32'(q_item.sig_digits) > 32'(MAX_DIGITS))
        begin
            start_cnt = REM_W'(MAX_DIGITS);
        end
        else
        begin
            start_cnt = REM_W'(q_item.sig_digits);
        end
    end

    always_comb
    begin
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        led_next   = led_reg;
        zero_next  = zero_reg;
        load_store = 1'b0;
        out_data_next.start_ignored = 1'b0;
        if (take)
        begin
            if (q_item.action)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    out_data_next.start_ignored = 1'b1;
                end
                else
                begin
                    load_store = 1'b1;
                    rem_next   = start_cnt;
                    pos_next   = '0;
                    phase_next = PH_ON;
                    tick_next  = '0;
                    led_next   = 1'b1;
                    zero_next  = q_item.zero;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_ON:
                    begin
                        if (tick_inc >= (hmlf_pkg::is_dash(cur_digit, pos_reg) ?
                                         long_on_reg : short_on_reg))
                        begin
                            phase_next = PH_SGAP;
                            tick_next  = '0;
                            led_next   = 1'b0;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_SGAP:
                    begin
                        if (tick_inc >= sym_gap_reg)
                        begin
                            pos_next  = pos_inc;
                            tick_next = '0;
                            if (pos_inc < hmlf_pkg::morse_len(cur_digit))
                            begin
                                phase_next = PH_ON;
                                led_next   = 1'b1;
                            end
                            else if (zero_reg || (digit_gap_reg == '0 && rem_dec == '0))
                            begin
                                phase_next = PH_IDLE;
                                led_next   = 1'b0;
                                rem_next   = '0;
                                pos_next   = '0;
                            end
                            else if (digit_gap_reg == '0)
                            begin
                                rem_next   = rem_dec;
                                pos_next   = '0;
                                phase_next = PH_ON;
                                led_next   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_DGAP;
                                led_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_DGAP:
                    begin
                        if (tick_inc >= digit_gap_reg)
                        begin
                            tick_next = '0;
                            pos_next  = '0;
                            rem_next  = rem_dec;
                            if (rem_dec != '0)
                            begin
                                phase_next = PH_ON;
                                led_next   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                led_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    default:
                    begin
                        led_next = 1'b0;
                    end
                endcase
            end
        end
        out_data_next.led_on   = led_next;
        out_data_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_on_reg  <= hmlf_pkg::SHORT_ON_RST;
            long_on_reg   <= hmlf_pkg::LONG_ON_RST;
            sym_gap_reg   <= hmlf_pkg::SYM_GAP_RST;
            digit_gap_reg <= hmlf_pkg::DIGIT_GAP_RST;
            rem_reg       <= '0;
            pos_reg       <= '0;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            led_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    hmlf_pkg::REG_SHORT_ON:  short_on_reg  <= cfg_data;
                    hmlf_pkg::REG_LONG_ON:   long_on_reg   <= cfg_data;
                    hmlf_pkg::REG_SYM_GAP:   sym_gap_reg   <= cfg_data;
                    hmlf_pkg::REG_DIGIT_GAP: digit_gap_reg <= cfg_data;
                    default:                 short_on_reg  <= short_on_reg;
                endcase
            end
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            led_reg   <= led_next;
            zero_reg  <= zero_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
        if (load_store)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                store_reg[i] <= hmlf_pkg::nibble_of(q_item.value, i);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/hex_morse_led_flasher_unit.sv =====
// Top level of the hex Morse LED flasher: front queue and Morse sequencer.
//
//  channel | signals                           | payload
//  --------+-----------------------------------+--------------------------------
//  in      | in_valid / in_ready               | in_data  (action, value)
//  out     | out_valid / out_ready             | out_data (led_on, busy_res,
//          |                                   |           start_ignored)
//  cfg     | cfg_valid / cfg_ready             | cfg_index, cfg_data
//
// One request per cycle while results are taken; each result passes through the
// two-entry front queue and then the sequencer's result register.
// The sequencer's state update for one tick or start is a registered feedback loop.
// Reset clears the queue, the sequencer state and loads the timing register defaults.
// A stalled result holds in its register; the front queue then fills and in_ready drops.
// cfg_ready is always high; a write takes effect on the next cycle.
module hex_morse_led_flasher_unit #(
    parameter int MAX_DIGITS = hmlf_pkg::MAX_DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hmlf_pkg::hmlf_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hmlf_pkg::hmlf_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hmlf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hmlf_pkg::TICK_W-1:0]    cfg_data
);

    logic                 q_valid;
    logic                 q_pop;
    hmlf_pkg::hmlf_item_t q_item;

    assign cfg_ready = 1'b1;

    hmlf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    hmlf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/hmlf_checker.sv =====
// Port-level checks for the hex Morse LED flasher, bound to the top level.
module hmlf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input hmlf_pkg::hmlf_out_t out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.start_ignored |-> out_data.busy_res)
        else $error("start dropped while idle");

    a_led_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.led_on |-> out_data.busy_res)
        else $error("LED lit while idle");

    a_full_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("queue full without a pending result");

endmodule

bind hex_morse_led_flasher_unit hmlf_checker u_hmlf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/hmlf_tb_pkg.sv =====
`timescale 1ns / 100ps
// Request action codes shared by the flasher testbench files.
package hmlf_tb_pkg;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

endpackage

// ===== bench/hmlf_flash_checker.sv =====
`timescale 1ns / 100ps
// Flasher checker: tracks timing writes, predicts each result and compares it in order.
module hmlf_flash_checker #(
    parameter int MAX_DIGITS = hmlf_pkg::MAX_DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  hmlf_pkg::hmlf_in_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  hmlf_pkg::hmlf_out_t            out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [hmlf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hmlf_pkg::TICK_W-1:0]    cfg_data,
    output int                             fails,
    output int                             pending,
    output int                             checked,
    output int                             dropped,
    output logic                           seq_busy
);
    import hmlf_pkg::*;
    import hmlf_tb_pkg::*;

    typedef enum logic [1:0] {
        FLASH_IDLE,
        FLASH_LIT,
        FLASH_SYM_GAP,
        FLASH_DIGIT_GAP
    } flash_state_e;

    logic [TICK_W-1:0]  dot_len;
    logic [TICK_W-1:0]  dash_len;
    logic [TICK_W-1:0]  sym_gap_len;
    logic [TICK_W-1:0]  digit_gap_len;
    logic [DIGIT_W-1:0] nibbles [MAX_DIGITS];
    int                 digits_left;
    logic [POS_W-1:0]   sym_idx;
    flash_state_e       flash_state;
    logic [TICK_W-1:0]  ticks;
    logic               led;
    logic               zero_run;
    hmlf_out_t          expected_q [$];

    // {symbol count, shape with the first symbol at bit 4, 1 = dash}
    function automatic logic [7:0] morse_entry(input logic [DIGIT_W-1:0] d);
        case (d)
            4'h0:    return {3'd5, 5'b11111};
            4'h1:    return {3'd5, 5'b01111};
            4'h2:    return {3'd5, 5'b00111};
            4'h3:    return {3'd5, 5'b00011};
            4'h4:    return {3'd5, 5'b00001};
            4'h5:    return {3'd5, 5'b00000};
            4'h6:    return {3'd5, 5'b10000};
            4'h7:    return {3'd5, 5'b11000};
            4'h8:    return {3'd5, 5'b11100};
            4'h9:    return {3'd5, 5'b11110};
            4'hA:    return {3'd2, 5'b01000};
            4'hB:    return {3'd4, 5'b10000};
            4'hC:    return {3'd4, 5'b10100};
            4'hD:    return {3'd3, 5'b10000};
            4'hE:    return {3'd1, 5'b00000};
            default: return {3'd4, 5'b00100};
        endcase
    endfunction

    function automatic logic [DIGIT_W-1:0] active_digit();
        if (digits_left < 1 || digits_left > MAX_DIGITS)
        begin
            return '0;
        end
        return nibbles[digits_left-1];
    endfunction

    function automatic logic dash_now();
        logic [7:0] e;
        e = morse_entry(active_digit());
        if (sym_idx >= e[7:5])
        begin
            return 1'b0;
        end
        return e[4 - sym_idx];
    endfunction

    task automatic count_tick(input logic [TICK_W-1:0] dur, output logic done);
        if (ticks != TICK_SAT)
        begin
            ticks = ticks + 1'b1;
        end
        done = (ticks >= dur);
    endtask

    task automatic light_symbol();
        flash_state = FLASH_LIT;
        ticks       = '0;
        led         = 1'b1;
    endtask

    task automatic go_dark();
        flash_state = FLASH_IDLE;
        ticks       = '0;
        led         = 1'b0;
        digits_left = 0;
        sym_idx     = '0;
    endtask

    task automatic next_digit();
        if (digits_left > 0)
        begin
            digits_left--;
        end
        if (digits_left > 0)
        begin
            sym_idx = '0;
            light_symbol();
        end
        else
        begin
            go_dark();
        end
    endtask

    task automatic advance_tick();
        logic       done;
        logic [7:0] e;
        case (flash_state)
            FLASH_LIT:
            begin
                count_tick(dash_now() ? dash_len : dot_len, done);
                if (done)
                begin
                    flash_state = FLASH_SYM_GAP;
                    ticks       = '0;
                    led         = 1'b0;
                end
            end
            FLASH_SYM_GAP:
            begin
                count_tick(sym_gap_len, done);
                if (done)
                begin
                    sym_idx = sym_idx + 1'b1;
                    e = morse_entry(active_digit());
                    if (sym_idx < e[7:5])
                    begin
                        light_symbol();
                    end
                    else if (zero_run)
                    begin
                        go_dark();
                    end
                    else if (digit_gap_len == '0)
                    begin
                        next_digit();
                    end
                    else
                    begin
                        flash_state = FLASH_DIGIT_GAP;
                        ticks       = '0;
                        led         = 1'b0;
                    end
                end
            end
            FLASH_DIGIT_GAP:
            begin
                count_tick(digit_gap_len, done);
                if (done)
                begin
                    next_digit();
                end
            end
            default:
            begin
                led = 1'b0;
            end
        endcase
    endtask

    task automatic load_value(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        int                 n;
        rest = v;
        n    = 0;
        if (v == '0)
        begin
            nibbles[0] = '0;
            n          = 1;
            zero_run   = 1'b1;
        end
        else
        begin
            zero_run = 1'b0;
            while (rest != '0 && n < MAX_DIGITS)
            begin
                nibbles[n] = rest[DIGIT_W-1:0];
                rest       = rest >> DIGIT_W;
                n++;
            end
        end
        digits_left = n;
        sym_idx     = '0;
        light_symbol();
    endtask

    task automatic flash_step(input hmlf_in_t req, output hmlf_out_t res);
        res.start_ignored = 1'b0;
        if (req.action == ACT_START)
        begin
            if (flash_state != FLASH_IDLE)
            begin
                res.start_ignored = 1'b1;
                dropped++;
            end
            else
            begin
                load_value(req.value);
            end
        end
        else
        begin
            advance_tick();
        end
        res.led_on   = led;
        res.busy_res = (flash_state != FLASH_IDLE);
    endtask

    task automatic compare_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        hmlf_out_t want;
        hmlf_out_t res;
        if (!rst_n)
        begin
            dot_len       = SHORT_ON_RST;
            dash_len      = LONG_ON_RST;
            sym_gap_len   = SYM_GAP_RST;
            digit_gap_len = DIGIT_GAP_RST;
            foreach (nibbles[i])
            begin
                nibbles[i] = '0;
            end
            go_dark();
            zero_run = 1'b0;
            expected_q.delete();
            fails   = 0;
            checked = 0;
            dropped = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SHORT_ON:  dot_len       = cfg_data;
                    REG_LONG_ON:   dash_len      = cfg_data;
                    REG_SYM_GAP:   sym_gap_len   = cfg_data;
                    REG_DIGIT_GAP: digit_gap_len = cfg_data;
                    default:       ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, out_data);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("led_on", want.led_on, out_data.led_on);
                    compare_field("busy_res", want.busy_res, out_data.busy_res);
                    compare_field("start_ignored", want.start_ignored,
                                  out_data.start_ignored);
                    checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                flash_step(in_data, res);
                expected_q.push_back(res);
            end
        end
        pending  = expected_q.size();
        seq_busy = (flash_state != FLASH_IDLE);
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Flasher testbench top: clock, reset, request and result traffic, timing setup, verdict.
module tb_top;
    import hmlf_pkg::*;
    import hmlf_tb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 400;
    localparam int PHASES         = 8;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    hmlf_in_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    hmlf_out_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SHORT_ON;
    logic [TICK_W-1:0]    cfg_data  = '0;

    int   fails;
    int   pending;
    int   checked;
    int   dropped;
    logic seq_busy;

    bit idle_on        = 1'b0;
    bit stall_on       = 1'b0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int items_sent     = 0;
    int idle_cycles    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    hex_morse_led_flasher_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hmlf_flash_checker flash_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .checked   (checked),
        .dropped   (dropped),
        .seq_busy  (seq_busy)
    );

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [31:0] r;
        r = $urandom();
        return r[VALUE_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] rand_ticks(input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(0, hi);
        return r[TICK_W-1:0];
    endfunction

    // mostly one or two digits, sometimes zero, full width or a chosen digit count
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0] w;
        logic [63:0] mask;
        int unsigned r;
        int          n;
        r    = $urandom_range(0, 15);
        n    = $urandom_range(1, 8);
        mask = (64'd1 << (4 * n)) - 64'd1;
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return rand_value();
        end
        if (r == 2)
        begin
            w = ({32'd0, $urandom()} & mask) | (64'd1 << (4 * n - 4));
            return w[VALUE_W-1:0];
        end
        w = {32'd0, $urandom_range(1, 255)};
        return w[VALUE_W-1:0];
    endfunction

    task automatic send_req(input logic act, input logic [VALUE_W-1:0] val);
        hmlf_in_t req;
        req.action = act;
        req.value  = val;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                              input logic [TICK_W-1:0] sgap, input logic [TICK_W-1:0] dgap);
        cfg_put(REG_SHORT_ON, dot);
        cfg_put(REG_LONG_ON, dash);
        cfg_put(REG_SYM_GAP, sgap);
        cfg_put(REG_DIGIT_GAP, dgap);
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_sequence(input bit noisy, input int pause_at);
        int k;
        k = 0;
        while (seq_busy)
        begin
            if (k == pause_at)
            begin
                in_valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
            end
            if (noisy && $urandom_range(0, 15) == 0)
            begin
                send_req(ACT_START, rand_value());
            end
            else
            begin
                send_req(ACT_TICK, rand_value());
                items_sent++;
            end
            k++;
        end
    endtask

    task automatic run_sequence(input logic [VALUE_W-1:0] val, input bit noisy);
        send_req(ACT_START, val);
        items_sent++;
        finish_sequence(noisy, -1);
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
                out_ready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int base;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_drained();
        send_req(ACT_TICK, '0);
        send_req(ACT_TICK, VALUE_MAX);
        wait_drained();
        set_timing('0, '0, '0, '0);
        send_req(ACT_START, '0);
        items_sent++;
        send_req(ACT_START, VALUE_MAX);
        finish_sequence(1'b0, 3);
        send_req(ACT_TICK, rand_value());
        run_sequence(31'hE, 1'b0);
        run_sequence(31'h1A, 1'b0);

        // long durations, one dot and one dash
        wait_drained();
        set_timing(16'd24, 16'd48, 16'd1, 16'd16);
        run_sequence(31'hA, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
            begin
                set_timing(16'd1, 16'd1, 16'd1, 16'd0);
            end
            else
            begin
                set_timing(rand_ticks(3), rand_ticks(4), rand_ticks(3), rand_ticks(3));
            end
            idle_on       = (p != 3) && (p != PHASES - 1);
            stall_on      = idle_on;
            long_hold_req = (p == 2);
            base = items_sent;
            if (p == 0)
            begin
                run_sequence(VALUE_MAX, 1'b1);
            end
            while (items_sent - base < RANDOM_ITEMS / PHASES)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_req(ACT_TICK, rand_value());
                end
                else
                begin
                    run_sequence(pick_value(), 1'b1);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d results over %0d counted requests; %0d busy starts dropped.",
                 checked, items_sent, dropped);
        $display("Covered directed cases, a long-duration timing run and %0d random phases.",
                 PHASES);
        if (fails == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hmlf_pkg.sv
rtl/core/hmlf_front.sv
rtl/core/hmlf_back.sv
rtl/core/hex_morse_led_flasher_unit.sv
rtl/core/hmlf_checker.sv
bench/hmlf_tb_pkg.sv
bench/hmlf_flash_checker.sv
bench/tb_top.sv
